/* design/mdio_prf_pkg.sv */
// shared types, constants and reset table for the mdio controller with phy register file
package mdio_prf_pkg;

	// default size of the internal phy register file
	localparam int unsigned PHY_REG_COUNT_DEF = 32;

	// command word layout
	localparam int unsigned BUSY_BIT   = 29;
	localparam int unsigned OP_RD_BIT  = 27;
	localparam int unsigned OP_WR_BIT  = 26;
	localparam int unsigned PHY_LSB    = 21;
	localparam int unsigned REG_LSB    = 16;
	localparam int unsigned FIELD_W    = 5;
	localparam int unsigned PHY_DATA_W = 16;

	localparam logic [PHY_DATA_W-1:0] DATA_ALL_ONES = 16'hffff;
	localparam logic [FIELD_W-1:0]    RESP_ADDR_RST = 5'h01;

	// bus access kinds
	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	// window offsets
	localparam logic [3:0] OFS_CMD = 4'h0;
	localparam logic [3:0] OFS_CFG = 4'h4;

	// output register occupancy
	typedef enum logic {
		ST_EMPTY,
		ST_FULL
	} ctrl_state_t;

	// controller to datapath command
	typedef struct packed {
		logic exec;
	} dp_cmd_t;

	// phy register file contents after reset: status and id words preset
	function automatic logic [PHY_DATA_W-1:0] rf_reset_word(input int unsigned idx);
		logic [PHY_DATA_W-1:0] w;
		case (idx)
			1:       w = 16'h796d;
			2:       w = 16'h600d;
			3:       w = 16'h84a2;
			default: w = '0;
		endcase
		return w;
	endfunction

endpackage

/* design/mdio_prf_ctrl.sv */
// controller for the mdio controller: input handshake and output register occupancy
module mdio_prf_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output mdio_prf_pkg::dp_cmd_t  cmd
);
	import mdio_prf_pkg::*;

	ctrl_state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_EMPTY;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handshake outputs
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		m_tvalid = 1'b0;
		cmd.exec = 1'b0;
		case (state_q)
			ST_EMPTY: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.exec = 1'b1;
					state_d  = ST_FULL;
				end
			end
			ST_FULL: begin
				m_tvalid = 1'b1;
				s_tready = m_tready;
				if (m_tready) begin
					if (s_tvalid) begin
						cmd.exec = 1'b1;
					end else begin
						state_d = ST_EMPTY;
					end
				end
			end
			default: begin
				state_d = ST_EMPTY;
			end
		endcase
	end

endmodule

/* design/mdio_prf_dp.sv */
// datapath for the mdio controller: window registers, phy register file and result register
module mdio_prf_dp #(
	parameter int unsigned PHY_REG_COUNT = mdio_prf_pkg::PHY_REG_COUNT_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  mdio_prf_pkg::dp_cmd_t              cmd,
	input  logic                               opcode,
	input  logic [3:0]                         offset,
	input  logic [31:0]                        write_data,
	input  logic                               cfg_we,
	input  logic [mdio_prf_pkg::FIELD_W-1:0]   cfg_wdata,
	output logic [31:0]                        read_data
);
	import mdio_prf_pkg::*;

	localparam int unsigned REG_AW = $clog2(PHY_REG_COUNT);

	logic [31:0]             cmd_q;
	logic [31:0]             clk_cfg_q;
	logic [FIELD_W-1:0]      resp_addr_q;
	logic [PHY_DATA_W-1:0]   rf_q [PHY_REG_COUNT];
	logic [31:0]             rdata_q;

	logic [FIELD_W-1:0]      phy_addr;
	logic [REG_AW-1:0]       reg_idx;
	logic [PHY_DATA_W-1:0]   rf_word;
	logic                    cmd_wr;
	logic                    cmd_load;
	logic [31:0]             cmd_d;
	logic                    rf_we;
	logic [31:0]             rdata_d;

	// decode of a command write
	assign phy_addr = write_data[PHY_LSB +: FIELD_W];
	assign reg_idx  = write_data[REG_LSB +: REG_AW];
	assign rf_word  = rf_q[reg_idx];
	assign cmd_wr   = cmd.exec && (opcode == OP_WRITE) && (offset == OFS_CMD);

	// command register update and phy file write
	always_comb begin
		cmd_load = 1'b0;
		rf_we    = 1'b0;
		cmd_d    = write_data;
		if (cmd_wr) begin
			if (phy_addr != resp_addr_q) begin
				cmd_load = 1'b1;
				cmd_d    = {write_data[31:PHY_DATA_W], DATA_ALL_ONES};
			end else if (write_data[OP_RD_BIT]) begin
				cmd_load = 1'b1;
				cmd_d    = {write_data[31:PHY_DATA_W], rf_word};
			end else if (write_data[OP_WR_BIT]) begin
				cmd_load = 1'b1;
				rf_we    = 1'b1;
			end
		end
	end

	// read result
	always_comb begin
		rdata_d = '0;
		if (opcode == OP_READ) begin
			case (offset)
				OFS_CMD: begin
					rdata_d           = cmd_q;
					rdata_d[BUSY_BIT] = 1'b0;
				end
				OFS_CFG: rdata_d = clk_cfg_q;
				default: rdata_d = '0;
			endcase
		end
	end

	// window registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q       <= '0;
			clk_cfg_q   <= '0;
			resp_addr_q <= RESP_ADDR_RST;
		end else begin
			if (cmd_load) begin
				cmd_q <= cmd_d;
			end
			if (cmd.exec && (opcode == OP_WRITE) && (offset == OFS_CFG)) begin
				clk_cfg_q <= write_data;
			end
			if (cfg_we) begin
				resp_addr_q <= cfg_wdata;
			end
		end
	end

	// phy register file, preset at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int unsigned i = 0; i < PHY_REG_COUNT; i++) begin
				rf_q[i] <= rf_reset_word(i);
			end
		end else if (rf_we) begin
			rf_q[reg_idx] <= write_data[PHY_DATA_W-1:0];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			rdata_q <= rdata_d;
		end
	end

	assign read_data = rdata_q;

`ifndef SYNTHESIS
	// a write transfer always answers zero
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && (opcode == OP_WRITE)) |=> (rdata_q == '0))
		else $error("write transfer returned nonzero data");

	// a command read never shows busy
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.exec && (opcode == OP_READ) && (offset == OFS_CMD)) |=> !rdata_q[BUSY_BIT])
		else $error("command read shows busy bit");

	// the phy file only changes on an accepted command write
	assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_wr |=> (rf_q[$past(reg_idx)] == $past(rf_word)))
		else $error("phy register file changed without a command write");
`endif

endmodule

/* design/mdio_controller_with_phy_regfile_unit.sv */
// top level of the mdio management controller with internal phy register file
//
//  channel   dir  handshake              payload
//  s_        in   s_tvalid / s_tready    s_tdata write_data, s_tuser opcode, offset
//  m_        out  m_tvalid / m_tready    m_tdata read_data
//  cfg_      in   cfg_we                 cfg_wdata responding phy address
//
// one transfer per cycle while the result is taken; the result is presented in the cycle after acceptance.
// the whole access completes in the accept cycle, the one-entry result register
// sets the figure and lets a new transfer in while the result is being taken.
// reset presets the phy register file in flops (status and id words), no sweep.
// when the result is stalled, input is held off until it is taken.
module mdio_controller_with_phy_regfile_unit #(
	parameter int unsigned PHY_REG_COUNT = mdio_prf_pkg::PHY_REG_COUNT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [31:0]                       s_tdata,   // [31:0] write_data
	input  logic [7:0]                        s_tuser,   // [0] opcode, [4:1] offset, [7:5] zero
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [31:0]                       m_tdata,   // [31:0] read_data
	input  logic                              cfg_we,
	input  logic [mdio_prf_pkg::FIELD_W-1:0]  cfg_wdata
);
	import mdio_prf_pkg::*;

	dp_cmd_t cmd;

	// handshake controller
	mdio_prf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	// registers and phy file
	mdio_prf_dp #(
		.PHY_REG_COUNT (PHY_REG_COUNT)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.opcode     (s_tuser[0]),
		.offset     (s_tuser[4:1]),
		.write_data (s_tdata),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.read_data  (m_tdata)
	);

endmodule
